/* src/llfh_pkg.sv */
`timescale 1ns / 1ps

package llfh_pkg;

	// Default pool size
	localparam int unsigned POOL_ENTRIES = 256;

	// Request codes
	localparam logic [2:0] REQ_APPEND    = 3'd0;
	localparam logic [2:0] REQ_TAKE_HEAD = 3'd1;
	localparam logic [2:0] REQ_REMOVE    = 3'd2;
	localparam logic [2:0] REQ_WALK_START = 3'd3;
	localparam logic [2:0] REQ_WALK_STEP = 3'd4;
	localparam logic [2:0] REQ_CLEAR     = 3'd5;

	// Status codes
	localparam logic [2:0] STATUS_OK       = 3'd0;
	localparam logic [2:0] STATUS_ZERO     = 3'd1;
	localparam logic [2:0] STATUS_FULL     = 3'd2;
	localparam logic [2:0] STATUS_EMPTY    = 3'd3;
	localparam logic [2:0] STATUS_BAD_HDL  = 3'd4;
	localparam logic [2:0] STATUS_WALK_END = 3'd5;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [31:0] item_value;
		logic [7:0]  entry_handle;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] value_out;
		logic [7:0]  handle_out;
		logic [8:0]  entry_count;
		logic        has_next;
	} rsp_t;

endpackage

/* src/llfh_ram.sv */
`timescale 1ns / 1ps

module llfh_ram #(
	parameter int unsigned Width = 1,
	parameter int unsigned Depth = 2,
	localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic             re,
	input  logic [AddrW-1:0] raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem [Depth];

	// Write one entry, read one entry with a registered output
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/linked_list_fifo_with_handles_core.sv */
`timescale 1ns / 1ps

// Doubly linked FIFO of nonzero 32-bit values held in a pool of PoolEntries entries. Each
// request transaction (append, take head, remove by handle, walk start, walk step, clear)
// yields exactly one response transaction carrying a status, the value taken or visited,
// the handle of an appended entry, the list length and whether the walk cursor is on an
// entry. Every request first reads the entry memories at the addressed entry and the free
// stack, then relinks and writes back; a new request is taken once the write-back cycle has
// placed its response in the output register, so a response waiting on a stalled consumer
// holds back at most one further request. No clearing pass is needed
// after reset or clear: fresh free-stack slots and never-allocated entries are recognized
// by a low watermark on the free stack.
module linked_list_fifo_with_handles_core #(
	parameter int unsigned PoolEntries = llfh_pkg::POOL_ENTRIES
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  llfh_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output llfh_pkg::rsp_t rsp
);

	localparam int unsigned HW = (PoolEntries > 1) ? $clog2(PoolEntries) : 1;
	localparam int unsigned LW = $clog2(PoolEntries + 1);
	localparam logic [LW-1:0] LinkNull = LW'(PoolEntries);
	localparam logic [LW-1:0] LastHandle = LW'(PoolEntries - 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic           state_q;
	logic [2:0]     req_s1;
	logic [31:0]    val_s1;
	logic [HW-1:0]  node_s1;
	logic           hok_s1;
	logic [LW-1:0]  head_q, tail_q, cursor_q, count_q, top_q, mark_q;
	logic           rsp_valid_q;
	llfh_pkg::rsp_t rsp_q;

	logic           accept, complete;
	logic [HW-1:0]  rd_node;
	logic [LW-1:0]  slot;
	logic [31:0]    val_rd;
	logic [HW-1:0]  nxt_rd, prv_rd, stk_rd;
	logic [0:0]     il_rd;

	logic [LW-1:0]  node_lw, n_link, p_link, fresh_lw;
	logic [LW:0]    alloc_sum;
	logic           fresh, il;
	logic [HW-1:0]  new_h;

	logic [LW-1:0]  head_d, tail_d, cursor_d, count_d, top_d, mark_d;
	logic [2:0]     status_d;
	logic [31:0]    vout_d;
	logic [7:0]     hout_d;

	logic           val_we, nxt_we, prv_we, il_we, stk_we;
	logic [HW-1:0]  val_wa, nxt_wa, prv_wa, il_wa, stk_wa;
	logic [HW-1:0]  nxt_wd, prv_wd, stk_wd;
	logic [0:0]     il_wd;

	// Handshake
	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign complete  = (state_q == ST_EXEC) && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Select the entry to read for the incoming request
	always_comb begin
		case (req.req_type)
			llfh_pkg::REQ_REMOVE:    rd_node = HW'(req.entry_handle);
			llfh_pkg::REQ_WALK_STEP: rd_node = cursor_q[HW-1:0];
			default:                 rd_node = head_q[HW-1:0];
		endcase
	end

	// Top slot of the free stack
	assign slot = top_q - LW'(1);

	// Entry memories
	llfh_ram #(.Width(32), .Depth(PoolEntries)) u_value (
		.clk(clk), .we(val_we), .waddr(val_wa), .wdata(val_s1),
		.re(accept), .raddr(rd_node), .rdata(val_rd)
	);

	llfh_ram #(.Width(HW), .Depth(PoolEntries)) u_next (
		.clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd),
		.re(accept), .raddr(rd_node), .rdata(nxt_rd)
	);

	llfh_ram #(.Width(HW), .Depth(PoolEntries)) u_prev (
		.clk(clk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd),
		.re(accept), .raddr(rd_node), .rdata(prv_rd)
	);

	llfh_ram #(.Width(1), .Depth(PoolEntries)) u_in_list (
		.clk(clk), .we(il_we), .waddr(il_wa), .wdata(il_wd),
		.re(accept), .raddr(rd_node), .rdata(il_rd)
	);

	llfh_ram #(.Width(HW), .Depth(PoolEntries)) u_free_stack (
		.clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd),
		.re(accept), .raddr(slot[HW-1:0]), .rdata(stk_rd)
	);

	// Resolve links: the head has no predecessor, the tail no successor
	assign node_lw = LW'(node_s1);
	assign n_link  = (node_lw == tail_q) ? LinkNull : LW'(nxt_rd);
	assign p_link  = (node_lw == head_q) ? LinkNull : LW'(prv_rd);

	// Entries above the watermark handle were never allocated since the last refill
	assign alloc_sum = {1'b0, node_lw} + {1'b0, mark_q};
	assign il        = il_rd[0] && (alloc_sum < {1'b0, LinkNull});

	// Stack slots below the watermark still hold their refill handle
	assign fresh    = (slot < mark_q);
	assign fresh_lw = LastHandle - slot;
	assign new_h    = fresh ? fresh_lw[HW-1:0] : stk_rd;

	// Execute the request and build the write-back
	always_comb begin
		logic do_unlink;

		do_unlink = 1'b0;
		head_d    = head_q;
		tail_d    = tail_q;
		cursor_d  = cursor_q;
		count_d   = count_q;
		top_d     = top_q;
		mark_d    = mark_q;
		status_d  = llfh_pkg::STATUS_OK;
		vout_d    = '0;
		hout_d    = '0;
		val_we    = 1'b0;
		val_wa    = new_h;
		nxt_we    = 1'b0;
		nxt_wa    = p_link[HW-1:0];
		nxt_wd    = n_link[HW-1:0];
		prv_we    = 1'b0;
		prv_wa    = n_link[HW-1:0];
		prv_wd    = p_link[HW-1:0];
		il_we     = 1'b0;
		il_wa     = node_s1;
		il_wd     = 1'b0;
		stk_we    = 1'b0;
		stk_wa    = top_q[HW-1:0];
		stk_wd    = node_s1;

		if (complete) begin
			case (req_s1)
				llfh_pkg::REQ_APPEND: begin
					if (val_s1 == '0) begin
						status_d = llfh_pkg::STATUS_ZERO;
					end else if (top_q == '0) begin
						status_d = llfh_pkg::STATUS_FULL;
					end else begin
						val_we = 1'b1;
						prv_we = 1'b1;
						prv_wa = new_h;
						prv_wd = tail_q[HW-1:0];
						il_we  = 1'b1;
						il_wa  = new_h;
						il_wd  = 1'b1;
						if (tail_q != LinkNull) begin
							nxt_we = 1'b1;
							nxt_wa = tail_q[HW-1:0];
							nxt_wd = new_h;
						end else begin
							head_d = LW'(new_h);
						end
						tail_d  = LW'(new_h);
						count_d = count_q + LW'(1);
						top_d   = slot;
						if (fresh) begin
							mark_d = slot;
						end
						hout_d = 8'(new_h);
					end
				end
				llfh_pkg::REQ_TAKE_HEAD: begin
					if (head_q == LinkNull) begin
						status_d = llfh_pkg::STATUS_EMPTY;
					end else begin
						do_unlink = 1'b1;
					end
				end
				llfh_pkg::REQ_REMOVE: begin
					if (!hok_s1 || !il) begin
						status_d = llfh_pkg::STATUS_BAD_HDL;
					end else begin
						do_unlink = 1'b1;
					end
				end
				llfh_pkg::REQ_WALK_START: begin
					cursor_d = head_q;
				end
				llfh_pkg::REQ_WALK_STEP: begin
					if (cursor_q == LinkNull) begin
						status_d = llfh_pkg::STATUS_WALK_END;
					end else begin
						vout_d   = val_rd;
						cursor_d = n_link;
					end
				end
				llfh_pkg::REQ_CLEAR: begin
					head_d   = LinkNull;
					tail_d   = LinkNull;
					cursor_d = LinkNull;
					count_d  = '0;
					top_d    = LinkNull;
					mark_d   = LinkNull;
				end
				default: begin
				end
			endcase

			// Unlink the addressed entry and return it to the free stack
			if (do_unlink) begin
				vout_d = val_rd;
				if (p_link != LinkNull) begin
					nxt_we = 1'b1;
				end else begin
					head_d = n_link;
				end
				if (n_link != LinkNull) begin
					prv_we = 1'b1;
				end else begin
					tail_d = p_link;
				end
				if (cursor_q == node_lw) begin
					cursor_d = n_link;
				end
				il_we = 1'b1;
				if (count_q != '0) begin
					count_d = count_q - LW'(1);
				end
				if (top_q != LinkNull) begin
					stk_we = 1'b1;
					top_d  = top_q + LW'(1);
				end
			end
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= LinkNull;
			tail_q      <= LinkNull;
			cursor_q    <= LinkNull;
			count_q     <= '0;
			top_q       <= LinkNull;
			mark_q      <= LinkNull;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (complete) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (complete) begin
				head_q   <= head_d;
				tail_q   <= tail_d;
				cursor_q <= cursor_d;
				count_q  <= count_d;
				top_q    <= top_d;
				mark_q   <= mark_d;
			end
			if (complete) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Hold the request and the response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1  <= req.req_type;
			val_s1  <= req.item_value;
			node_s1 <= rd_node;
			hok_s1  <= (32'(req.entry_handle) < 32'(PoolEntries));
		end
		if (complete) begin
			rsp_q.status      <= status_d;
			rsp_q.value_out   <= vout_d;
			rsp_q.handle_out  <= hout_d;
			rsp_q.entry_count <= 9'(count_d);
			rsp_q.has_next    <= (cursor_d != LinkNull);
		end
	end

	// Every entry is either listed or on the free stack
	assert property (@(posedge clk) disable iff (!arst_n)
		(32'(count_q) + 32'(top_q)) == 32'(PoolEntries))
		else $error("entry count and free stack do not add up to the pool");

	// Head and tail are null together
	assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == LinkNull) == (tail_q == LinkNull))
		else $error("head and tail disagree on an empty list");

	// The watermark never rises above the stack top
	assert property (@(posedge clk) disable iff (!arst_n)
		mark_q <= top_q)
		else $error("free stack watermark above stack top");

	// A response appears only after a write-back cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == ST_EXEC)
		else $error("response raised without a write-back cycle");

endmodule

/* dv/linked_list_fifo_with_handles_core_tb.sv */
`timescale 1ns / 1ps

module linked_list_fifo_with_handles_core_tb;

	localparam logic [8:0] LINK_NULL = 9'(llfh_pkg::POOL_ENTRIES);

	// Request codes the block leaves unused
	localparam logic [2:0] REQ_UNUSED_LO = 3'd6;
	localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

	// Random traffic mixes
	localparam int PROF_MIXED = 0;
	localparam int PROF_FILL  = 1;
	localparam int PROF_DRAIN = 2;
	localparam int PROF_WALK  = 3;

	localparam int RANDOM_ITEMS = 1750;
	localparam int HOLD_CYCLES  = 400;
	localparam int CYCLE_LIMIT  = 500000;

	// Mirror of the list state; each accepted request queues the response it owes
	class handle_list_checker;
		logic [31:0]     value_store [llfh_pkg::POOL_ENTRIES];
		logic [8:0]      next_link   [llfh_pkg::POOL_ENTRIES];
		logic [8:0]      prev_link   [llfh_pkg::POOL_ENTRIES];
		bit              in_list     [llfh_pkg::POOL_ENTRIES];
		logic [7:0]      free_stack  [llfh_pkg::POOL_ENTRIES];
		logic [8:0]      free_top;
		logic [8:0]      head_link;
		logic [8:0]      tail_link;
		logic [8:0]      count;
		logic [8:0]      walk_cursor;
		llfh_pkg::rsp_t  owed_rsps [$];
		int              errors;

		function new();
			errors = 0;
			refill();
		endfunction

		// Return every entry to the free stack, handle 0 on top
		function void refill();
			for (int i = 0; i < llfh_pkg::POOL_ENTRIES; i++) begin
				free_stack[i] = 8'(llfh_pkg::POOL_ENTRIES - 1 - i);
				in_list[i] = 1'b0;
			end
			free_top = 9'(llfh_pkg::POOL_ENTRIES);
			head_link = LINK_NULL;
			tail_link = LINK_NULL;
			count = '0;
			walk_cursor = LINK_NULL;
		endfunction

		// Unlink an entry that is in the list and give back its value
		function logic [31:0] unlink(logic [7:0] h);
			logic [8:0] p;
			logic [8:0] n;
			p = prev_link[h];
			n = next_link[h];
			if (p != LINK_NULL)
				next_link[p[7:0]] = n;
			else
				head_link = n;
			if (n != LINK_NULL)
				prev_link[n[7:0]] = p;
			else
				tail_link = p;
			// the cursor slides on to the successor
			if (walk_cursor == {1'b0, h})
				walk_cursor = n;
			in_list[h] = 1'b0;
			if (count != 0)
				count--;
			if (free_top < LINK_NULL) begin
				free_stack[free_top[7:0]] = h;
				free_top++;
			end
			return value_store[h];
		endfunction

		function llfh_pkg::rsp_t apply_request(llfh_pkg::req_t r);
			llfh_pkg::rsp_t o;
			logic [7:0] h;
			o = '0;
			case (r.req_type)
				llfh_pkg::REQ_APPEND: begin
					if (r.item_value == 0) begin
						o.status = llfh_pkg::STATUS_ZERO;
					end else if (free_top == 0) begin
						o.status = llfh_pkg::STATUS_FULL;
					end else begin
						free_top--;
						h = free_stack[free_top[7:0]];
						value_store[h] = r.item_value;
						next_link[h] = LINK_NULL;
						prev_link[h] = tail_link;
						if (tail_link != LINK_NULL)
							next_link[tail_link[7:0]] = {1'b0, h};
						else
							head_link = {1'b0, h};
						tail_link = {1'b0, h};
						in_list[h] = 1'b1;
						count++;
						o.handle_out = h;
					end
				end
				llfh_pkg::REQ_TAKE_HEAD: begin
					if (head_link == LINK_NULL)
						o.status = llfh_pkg::STATUS_EMPTY;
					else
						o.value_out = unlink(head_link[7:0]);
				end
				llfh_pkg::REQ_REMOVE: begin
					if (!in_list[r.entry_handle])
						o.status = llfh_pkg::STATUS_BAD_HDL;
					else
						o.value_out = unlink(r.entry_handle);
				end
				llfh_pkg::REQ_WALK_START: begin
					walk_cursor = head_link;
				end
				llfh_pkg::REQ_WALK_STEP: begin
					if (walk_cursor == LINK_NULL) begin
						o.status = llfh_pkg::STATUS_WALK_END;
					end else begin
						o.value_out = value_store[walk_cursor[7:0]];
						walk_cursor = next_link[walk_cursor[7:0]];
					end
				end
				llfh_pkg::REQ_CLEAR: begin
					refill();
				end
				default: begin
				end
			endcase
			o.entry_count = count;
			o.has_next = (walk_cursor != LINK_NULL);
			return o;
		endfunction

		function void note_request(llfh_pkg::req_t r);
			owed_rsps.push_back(apply_request(r));
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, got %0h", field, want, got);
				errors++;
			end
		endfunction

		function void check_response(llfh_pkg::rsp_t got);
			llfh_pkg::rsp_t want;
			if (owed_rsps.size() == 0) begin
				$error("response transaction with no request outstanding (status %0d)",
					got.status);
				errors++;
				return;
			end
			want = owed_rsps.pop_front();
			compare("status", 32'(want.status), 32'(got.status));
			compare("value_out", want.value_out, got.value_out);
			compare("handle_out", 32'(want.handle_out), 32'(got.handle_out));
			compare("entry_count", 32'(want.entry_count), 32'(got.entry_count));
			compare("has_next", 32'(want.has_next), 32'(got.has_next));
		endfunction

		function int pending();
			return owed_rsps.size();
		endfunction

		// Some handle currently in the list, searched from a random start
		function logic [7:0] live_handle();
			logic [7:0] h;
			h = 8'($urandom_range(0, llfh_pkg::POOL_ENTRIES - 1));
			for (int i = 0; i < llfh_pkg::POOL_ENTRIES; i++) begin
				if (in_list[h])
					return h;
				h++;
			end
			return h;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	llfh_pkg::req_t req;
	logic rsp_valid;
	logic rsp_stall;
	llfh_pkg::rsp_t rsp;

	handle_list_checker list_chk;
	bit steady;
	bit hold_rsp;
	int cycles;

	linked_list_fifo_with_handles_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL linked_list_fifo_with_handles_core");
			$finish;
		end
	end

	function automatic llfh_pkg::req_t mk(logic [2:0] kind, logic [31:0] value,
		logic [7:0] hdl);
		llfh_pkg::req_t r;
		r.req_type = kind;
		r.item_value = value;
		r.entry_handle = hdl;
		return r;
	endfunction

	function automatic llfh_pkg::req_t make_request(int profile);
		llfh_pkg::req_t r;
		int roll;
		int cut [6];
		roll = $urandom_range(0, 99);
		r.item_value = $urandom;
		r.entry_handle = 8'($urandom);
		case (profile)
			PROF_FILL:  cut = '{88, 90, 93, 95, 99, 99};
			PROF_DRAIN: cut = '{15, 50, 85, 88, 97, 100};
			PROF_WALK:  cut = '{25, 30, 45, 55, 99, 99};
			default:    cut = '{40, 55, 75, 82, 96, 98};
		endcase
		if (roll < cut[0]) begin
			r.req_type = llfh_pkg::REQ_APPEND;
			case ($urandom_range(0, 39))
				0: r.item_value = '0;
				1: r.item_value = '1;
				default: ;
			endcase
		end else if (roll < cut[1]) begin
			r.req_type = llfh_pkg::REQ_TAKE_HEAD;
		end else if (roll < cut[2]) begin
			r.req_type = llfh_pkg::REQ_REMOVE;
			// mostly aim at live entries, sometimes at the one under the cursor
			if (list_chk.count != 0 && $urandom_range(0, 3) != 0) begin
				if (profile == PROF_WALK && list_chk.walk_cursor != LINK_NULL
						&& $urandom_range(0, 1) == 1)
					r.entry_handle = list_chk.walk_cursor[7:0];
				else
					r.entry_handle = list_chk.live_handle();
			end
		end else if (roll < cut[3]) begin
			r.req_type = llfh_pkg::REQ_WALK_START;
		end else if (roll < cut[4]) begin
			r.req_type = llfh_pkg::REQ_WALK_STEP;
		end else if (roll < cut[5]) begin
			r.req_type = llfh_pkg::REQ_CLEAR;
		end else begin
			r.req_type = $urandom_range(0, 1) ? REQ_UNUSED_HI : REQ_UNUSED_LO;
		end
		return r;
	endfunction

	// Offer one request transaction after a random gap and hold it until taken
	task automatic push_request(llfh_pkg::req_t item);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 13);
		repeat (gap) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (req_stall);
		list_chk.note_request(item);
	endtask

	// Accept response transactions with random stalls, or one long hold on request
	initial begin
		int n;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_rsp) begin
				n = HOLD_CYCLES;
				hold_rsp = 1'b0;
			end else begin
				n = steady ? 0 : $urandom_range(0, 13);
			end
			repeat (n) begin
				@(negedge clk);
				rsp_stall <= 1'b1;
			end
			@(negedge clk);
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
			list_chk.check_response(rsp);
		end
	end

	initial begin
		int random_sent;
		int phase;
		int profile;
		int length;
		list_chk = new();
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		steady = 1'b0;
		hold_rsp = 1'b0;
		cycles = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty-list errors, zero value, extremes, cursor moves, spare codes
		push_request(mk(llfh_pkg::REQ_TAKE_HEAD, 32'h0, 8'h00));
		push_request(mk(llfh_pkg::REQ_WALK_STEP, 32'h0, 8'h00));
		push_request(mk(llfh_pkg::REQ_WALK_START, 32'h0, 8'h00));
		push_request(mk(llfh_pkg::REQ_REMOVE, 32'h0, 8'h00));
		push_request(mk(llfh_pkg::REQ_APPEND, 32'h0, 8'h00));
		push_request(mk(llfh_pkg::REQ_APPEND, 32'hFFFF_FFFF, 8'hFF));
		push_request(mk(llfh_pkg::REQ_APPEND, 32'h0000_0001, 8'h00));
		push_request(mk(llfh_pkg::REQ_APPEND, 32'h8000_0000, 8'h00));
		push_request(mk(llfh_pkg::REQ_APPEND, 32'h5A5A_A5A5, 8'h00));
		push_request(mk(llfh_pkg::REQ_WALK_START, 32'h0, 8'h00));
		push_request(mk(llfh_pkg::REQ_WALK_STEP, 32'h0, 8'h00));
		push_request(mk(llfh_pkg::REQ_REMOVE, 32'h0, 8'h01));
		push_request(mk(llfh_pkg::REQ_WALK_STEP, 32'h0, 8'h00));
		push_request(mk(llfh_pkg::REQ_TAKE_HEAD, 32'h0, 8'h00));
		push_request(mk(llfh_pkg::REQ_REMOVE, 32'h0, 8'hFF));
		push_request(mk(llfh_pkg::REQ_REMOVE, 32'h0, 8'h03));
		push_request(mk(llfh_pkg::REQ_WALK_STEP, 32'h0, 8'h00));
		push_request(mk(REQ_UNUSED_LO, 32'hFFFF_FFFF, 8'hFF));
		push_request(mk(REQ_UNUSED_HI, 32'h1234_5678, 8'h55));
		push_request(mk(llfh_pkg::REQ_APPEND, 32'h7FFF_FFFF, 8'h00));
		push_request(mk(llfh_pkg::REQ_WALK_START, 32'h0, 8'h00));
		push_request(mk(llfh_pkg::REQ_TAKE_HEAD, 32'h0, 8'h00));
		push_request(mk(llfh_pkg::REQ_CLEAR, 32'h0, 8'h00));
		push_request(mk(llfh_pkg::REQ_WALK_STEP, 32'h0, 8'h00));
		push_request(mk(llfh_pkg::REQ_REMOVE, 32'h0, 8'hAA));

		// Random phases: first fill the pool past full, then varied mixes
		random_sent = 0;
		phase = 0;
		while (random_sent < RANDOM_ITEMS) begin
			profile = (phase == 0) ? PROF_FILL : $urandom_range(PROF_MIXED, PROF_WALK);
			length = (phase == 0) ? 320 : $urandom_range(60, 160);
			steady = (phase % 3 == 2);
			// back up the block behind a stalled consumer
			if (phase == 1)
				hold_rsp = 1'b1;
			// let the block drain completely before going on
			if (phase == 3) begin
				@(negedge clk);
				req_valid <= 1'b0;
				while (list_chk.pending() != 0) @(posedge clk);
			end
			repeat (length) begin
				push_request(make_request(profile));
				random_sent++;
			end
			phase++;
		end
		@(negedge clk);
		req_valid <= 1'b0;

		// Drain, then watch for stray responses
		while (list_chk.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (list_chk.errors == 0 && list_chk.pending() == 0)
			$display("PASS linked_list_fifo_with_handles_core");
		else
			$display("FAIL linked_list_fifo_with_handles_core");
		$finish;
	end

endmodule
